// ----- design/acmac_pkg.sv -----
// package for the aes-cmac tag engine: widths, codes, sbox and round helpers
package acmac_pkg;

  localparam int unsigned DefaultMaxMsgBytes = 4096;
  localparam int unsigned TotalW = 17;
  localparam logic [TotalW-1:0] TotalSat = '1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_KLEN  = 3'd4
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TOOLONG = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REQ_COMPUTE = 1'b0,
    REQ_VERIFY  = 1'b1
  } req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_KEXP,
    S_L_INIT,
    S_L_ROUND,
    S_SUBKEY,
    S_BLK_INIT,
    S_BLK_ROUND,
    S_FINISH,
    S_OUT
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // substitute all four bytes of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one aes round without the key add; byte 0 is the top byte of the state
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        t[4*c+row] = SBOX[b[4*((c+row)%4)+row]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last_rnd) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                             xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
    end
    aes_round = r;
  endfunction

  function automatic logic [127:0] gf_dbl(input logic [127:0] v);
    gf_dbl = {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

endpackage

// ----- design/aes_cmac_tag_engine_top.sv -----
// aes-cmac tag engine: one beat per 16-byte block, shared aes round unit
// a beat is taken only in idle; the block then stays busy through init, the key add and
// nr rounds, and finish, so a new beat is taken only once the last one is through
// first beat of a message adds key expansion (one word per cycle) and the zero-block
// encryption with subkey step; an invalid key length skips both
// last beat: tvalid rises after finish and holds until tready
// rst is synchronous active high; clears control, key registers, chaining value and byte total
module aes_cmac_tag_engine_top #(
  parameter int unsigned MAX_MSG_BYTES = acmac_pkg::DefaultMaxMsgBytes
) (
  input  logic          clk,
  input  logic          rst,
  // cfg write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: data_hi, data_lo, byte_count, expected_tag_hi, expected_tag_lo,
  // tag_length, zero fill (lowest bit first)
  input  logic [279:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  // tuser: req_type
  input  logic          s_axis_tuser,
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: tag_hi, tag_lo, status, zero fill (lowest bit first)
  output logic [135:0]  m_axis_tdata
);
  import acmac_pkg::*;

  // field unpack
  logic [63:0] in_dhi, in_dlo, in_ehi, in_elo;
  logic [4:0]  in_cnt;
  logic [15:0] in_tlen;
  assign in_dhi  = s_axis_tdata[63:0];
  assign in_dlo  = s_axis_tdata[127:64];
  assign in_cnt  = s_axis_tdata[132:128];
  assign in_ehi  = s_axis_tdata[196:133];
  assign in_elo  = s_axis_tdata[260:197];
  assign in_tlen = s_axis_tdata[276:261];

  // configuration registers
  logic [63:0] key0, key1, key2, key3;
  logic [7:0]  key_bytes;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0;
      key_bytes <= 8'd16;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY0: key0 <= cfg_data;
        CFG_KEY1: key1 <= cfg_data;
        CFG_KEY2: key2 <= cfg_data;
        CFG_KEY3: key3 <= cfg_data;
        CFG_KLEN: key_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // round key memory (60 words as 15 round keys, each written once its four words are ready, one round key read)
  logic [127:0] rk_mem [15];
  logic [127:0] rk_rd;
  logic [3:0]   rk_raddr;

  // state
  state_t      state, state_next;
  logic        in_message;
  logic        nr14;          // latched key length is 256 bits
  logic        key_ok;        // latched key length is valid
  logic [127:0] cv;           // chaining value
  logic [127:0] st;           // round unit state
  logic [127:0] k1, k2;
  logic [TotalW-1:0] total;
  logic [3:0]  rnd;
  logic [5:0]  widx;          // key expansion word index
  logic [255:0] kwin;         // last eight expanded words, newest lowest
  logic [7:0]  rcon;
  logic        have_l;        // current encryption derives subkeys
  // held item
  logic        h_last, h_req;
  logic [127:0] h_blk;
  logic [4:0]  h_cnt;
  logic [127:0] h_exp;
  logic [15:0] h_tlen;
  logic [127:0] out_tag;
  logic [1:0]  out_st;

  logic [3:0] nr;
  assign nr = nr14 ? 4'd14 : 4'd10;

  assign s_axis_tready = (state == S_IDLE);
  logic take;
  assign take = s_axis_tvalid && s_axis_tready;

  // key expansion word step
  logic [31:0] w_prev, w_back, w_new, w_t;
  logic [5:0]  w_total;
  logic        nk8;
  assign nk8 = nr14;
  assign w_total = nk8 ? 6'd60 : 6'd44;
  assign w_prev = kwin[31:0];
  assign w_back = nk8 ? kwin[255:224] : kwin[127:96];
  always_comb begin
    if ((nk8 && widx[2:0] == 3'd0) || (!nk8 && widx[1:0] == 2'd0)) begin
      w_t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {rcon, 24'h0};
    end else if (nk8 && widx[2:0] == 3'd4) begin
      w_t = sub_word(w_prev);
    end else begin
      w_t = w_prev;
    end
    w_new = w_back ^ w_t;
  end

  // round key read and shared round unit
  always_ff @(posedge clk) rk_rd <= rk_mem[rk_raddr];
  logic [127:0] round_out;
  assign round_out = aes_round(st, rnd == nr);

  // padded final block
  logic [127:0] pad_blk;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (i < h_cnt) pad_blk[127-8*i -: 8] = h_blk[127-8*i -: 8];
      else if (i == h_cnt) pad_blk[127-8*i -: 8] = 8'h80;
      else pad_blk[127-8*i -: 8] = 8'h00;
    end
  end

  logic [TotalW:0] total_sum;
  logic [4:0] add_n;
  assign add_n = h_last ? h_cnt : 5'd16;
  assign total_sum = {1'b0, total} + {{(TotalW-4){1'b0}}, add_n};

  // next state; round key reads run one round ahead
  always_comb begin
    state_next = state;
    rk_raddr = 4'd0;
    unique case (state)
      S_IDLE: begin
        if (take) state_next = in_message ? S_BLK_INIT : S_KEXP;
      end
      S_KEXP: begin
        if (key_ok == 1'b0) state_next = S_FINISH;
        else if (widx == w_total) state_next = S_L_INIT;
      end
      S_L_INIT: begin
        rk_raddr = 4'd0;
        state_next = S_L_ROUND;
      end
      S_L_ROUND, S_BLK_ROUND: begin
        rk_raddr = (rnd == nr) ? 4'd0 : rnd + 4'd1;
        if (rnd == nr) state_next = have_l ? S_SUBKEY : S_FINISH;
      end
      S_SUBKEY: state_next = S_BLK_INIT;
      S_BLK_INIT: begin
        rk_raddr = 4'd0;
        state_next = key_ok ? S_BLK_ROUND : S_FINISH;
      end
      S_FINISH: state_next = h_last ? S_OUT : S_IDLE;
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      cv <= '0;
      total <= '0;
      key_ok <= 1'b0;
      nr14 <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            h_last <= s_axis_tlast;
            h_req  <= s_axis_tuser;
            h_blk  <= {in_dhi, in_dlo};
            h_cnt  <= (!s_axis_tlast || in_cnt > 5'd16) ? 5'd16 : in_cnt;
            h_exp  <= {in_ehi, in_elo};
            h_tlen <= in_tlen;
            have_l <= 1'b0;
            if (!in_message) begin
              in_message <= 1'b1;
              cv <= '0;
              total <= '0;
              key_ok <= (key_bytes == 8'd16) || (key_bytes == 8'd32);
              nr14 <= (key_bytes == 8'd32);
              kwin <= (key_bytes == 8'd32) ? {key0, key1, key2, key3}
                                           : {128'd0, key0, key1};
              widx <= (key_bytes == 8'd32) ? 6'd8 : 6'd4;
              rcon <= 8'h01;
              if (key_bytes == 8'd32) begin
                rk_mem[0] <= {key0, key1};
                rk_mem[1] <= {key2, key3};
              end else begin
                rk_mem[0] <= {key0, key1};
              end
            end
          end
        end
        S_KEXP: begin
          if (key_ok && widx != w_total) begin
            kwin <= {kwin[223:0], w_new};
            widx <= widx + 6'd1;
            if ((nk8 && widx[2:0] == 3'd0) || (!nk8 && widx[1:0] == 2'd0))
              rcon <= xtime(rcon);
            if (widx[1:0] == 2'd3)
              rk_mem[widx[5:2]] <= {kwin[95:0], w_new};
          end
          have_l <= 1'b1;
          st <= '0;
        end
        S_L_INIT, S_BLK_INIT: begin
          // the read issued here returns round key 0 next cycle; fold it then
          rnd <= 4'd0;
          if (state == S_BLK_INIT) begin
            if (!h_last) st <= cv ^ h_blk;
            else if (h_cnt == 5'd16) st <= cv ^ h_blk ^ k1;
            else st <= cv ^ pad_blk ^ k2;
          end
        end
        S_L_ROUND, S_BLK_ROUND: begin
          if (rnd == 4'd0) st <= st ^ rk_rd;
          else st <= round_out ^ rk_rd;
          rnd <= rnd + 4'd1;
        end
        S_SUBKEY: begin
          k1 <= gf_dbl(st);
          k2 <= gf_dbl(gf_dbl(st));
          have_l <= 1'b0;
        end
        S_FINISH: begin
          total <= total_sum[TotalW] ? TotalSat : total_sum[TotalW-1:0];
          if (!h_last) begin
            cv <= st;
          end else begin
            in_message <= 1'b0;
            cv <= '0;
            out_tag <= '0;
            if (!key_ok) out_st <= ST_INVALID;
            else if (total_sum > (TotalW+1)'(MAX_MSG_BYTES)) out_st <= ST_TOOLONG;
            else if (h_req == REQ_VERIFY)
              out_st <= (h_tlen != 16'd16 || st != h_exp) ? ST_INVALID : ST_OK;
            else begin
              out_st <= ST_OK;
              out_tag <= st;
            end
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, out_st, out_tag[63:0], out_tag[127:64]};

endmodule
